>>> rtl/core/tagged_stack_engine_defines.svh
// Assertion macros for the tagged stack engine
`ifndef TAGGED_STACK_ENGINE_DEFINES_SVH
`define TAGGED_STACK_ENGINE_DEFINES_SVH

// implication checked every cycle outside reset
`define TSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define TSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Types, codes and constants shared by the tagged stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tse_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 3;

    localparam logic [KIND_W-1:0] K_PUSH    = 4'd0;
    localparam logic [KIND_W-1:0] K_POP     = 4'd1;
    localparam logic [KIND_W-1:0] K_PEEK    = 4'd2;
    localparam logic [KIND_W-1:0] K_CLEAR   = 4'd3;
    localparam logic [KIND_W-1:0] K_DUP     = 4'd4;
    localparam logic [KIND_W-1:0] K_SWAP    = 4'd5;
    localparam logic [KIND_W-1:0] K_ROTATE  = 4'd6;
    localparam logic [KIND_W-1:0] K_SEARCH  = 4'd7;
    localparam logic [KIND_W-1:0] K_REVERSE = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_FEW      = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADN     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,      // issue read of top/scan word
        S_WAIT,      // read data comes back
        S_SCAN,      // search compare
        S_SWAP_A,    // reverse: read next low word
        S_SWAP_B,
        S_SWAP_W,    // write the other word back
        S_ROT,       // rotate step
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic        load;       // latch command
        logic        rd_a;       // read addr_a into data_a
        logic        rd_b;       // read addr_b into data_b
        logic        wr_a;       // write data_b at addr_a
        logic        wr_b;       // write data_a at addr_b
        logic        wr_push;    // write input word at fill
        logic        wr_dup;     // write data_a at fill
        logic        rot_init;
        logic        rot_step;   // write data_a above addr_a, move addr down
        logic        rev_init;
        logic        rev_step;
        logic        scan_step;
        logic        fill_inc;
        logic        fill_dec;
        logic        fill_clr;
        logic        set_read;   // copy data_a to read fields
        logic        set_found;
        logic [STAT_W-1:0] status;
        logic        set_status;
        logic        out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic        empty;
        logic        full;
        logic        few;
        logic        bad_rot;
        logic        match;
        logic        scan_last;
        logic        ptr_meet;   // reverse/rotate finished
        logic        out_busy;
    } stat_t;

    function automatic logic words_equal(input logic [31:0] a, input logic [31:0] b,
                                         input logic tag);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (!tag)
            return a == b;
        if (a_nan || b_nan)
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b1;
        return a == b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tse_if.sv
// ----------------------------------------------------------------------------
// tse_cmd_if / tse_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tse_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] word_value;
    logic        word_tag;
    logic [10:0] rotate_count;
    modport source (output valid, kind, word_value, word_tag, rotate_count, input ready);
    modport sink   (input valid, kind, word_value, word_tag, rotate_count, output ready);
endinterface

interface tse_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [31:0]        read_value;
    logic               read_tag;
    logic signed [10:0] found_position;
    logic [10:0]        depth_now;
    logic [10:0]        high_water;
    modport source (output valid, status, read_value, read_tag, found_position,
                    depth_now, high_water, input ready);
    modport sink   (input valid, status, read_value, read_tag, found_position,
                    depth_now, high_water, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tagged_stack_engine.sv
// ----------------------------------------------------------------------------
// tagged_stack_engine
// Bounded LIFO of tagged 32-bit words with search, rotate and reverse.
// ----------------------------------------------------------------------------
// channel  dir  transfer
// cmd      in   kind, word_value, word_tag, rotate_count
// res      out  status, read_value, read_tag, found_position, depth_now, high_water
//
// push, clear, failed commands go READ, DONE; pop, peek, dup add WAIT; swap adds
// WAIT, SWAP_B, SWAP_W. search, rotate and reverse loop once per word or pair,
// all set by the single read port of the word store.
// Reset clears fill and peak counts; the store itself is not cleared.
// A result waits in the output register; a new command is taken once it leaves.
`timescale 1ns / 1ps
`default_nettype none
module tagged_stack_engine
    import tse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    tse_cmd_if.sink    cmd,
    tse_res_if.source  res
);
    cmd_t  ctl;
    stat_t sts;

    tse_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    tse_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .ctl   (ctl),
        .sts   (sts)
    );
endmodule
`default_nettype wire

>>> rtl/core/tse_datapath.sv
// ----------------------------------------------------------------------------
// tse_datapath
// Word store, fill and peak counters, pointers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tse_datapath
    import tse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    tse_cmd_if.sink     cmd,
    tse_res_if.source   res,
    input  cmd_t        ctl,
    output stat_t       sts
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(STACK_DEPTH);

    logic [32:0] mem [STACK_DEPTH];

    logic [KIND_W-1:0] kind_reg;
    logic [31:0] val_reg;
    logic        tag_reg;
    logic [FW-1:0] n_reg;
    logic [FW-1:0] fill_reg, peak_reg;
    logic [AW-1:0] addr_a_reg, addr_b_reg;
    logic [32:0] data_a_reg, data_b_reg, hold_reg;

    logic               rv_reg;
    logic [2:0]         r_status_reg;
    logic [31:0]        r_val_reg;
    logic               r_tag_reg;
    logic [10:0]        r_found_reg;

    logic [FW-1:0] n_in;
    logic [AW-1:0] top_a, sec_a;

    assign n_in  = (FW >= COUNT_W) ? FW'(cmd.rotate_count) :
                   ((cmd.rotate_count > COUNT_W'(STACK_DEPTH)) ? DEPTH_F + FW'(1)
                                                                : FW'(cmd.rotate_count));
    assign top_a = AW'(fill_reg - FW'(1));
    assign sec_a = AW'(fill_reg - FW'(2));

    // memory: two reads and two writes are never issued in the same cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_push)
            mem[AW'(fill_reg)] <= {tag_reg, val_reg};
        else if (ctl.wr_dup)
            mem[AW'(fill_reg)] <= data_a_reg;
        else if (ctl.wr_a)
            mem[addr_a_reg] <= data_b_reg;
        else if (ctl.wr_b)
            mem[addr_b_reg] <= data_a_reg;
        else if (ctl.rot_step)
        begin
            // last step drops the old top word into the base slot
            if (sts.ptr_meet)
                mem[addr_b_reg] <= hold_reg;
            else
                mem[addr_a_reg + AW'(1)] <= data_a_reg;
        end
        if (ctl.rd_a)
            data_a_reg <= mem[addr_a_reg];
        else if (ctl.rd_b)
            data_b_reg <= mem[addr_b_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            val_reg <= cmd.word_value;
            tag_reg <= cmd.word_tag;
            n_reg   <= n_in;
            addr_a_reg <= top_a;
            addr_b_reg <= sec_a;
        end
        else if (ctl.rot_init)
        begin
            hold_reg   <= data_a_reg;
            addr_b_reg <= AW'(fill_reg - n_reg);
            addr_a_reg <= top_a - AW'(1);
        end
        else if (ctl.rot_step)
        begin
            // data_a holds word at addr_a; written one place up
            addr_a_reg <= addr_a_reg - AW'(1);
        end
        else if (ctl.rev_init)
        begin
            addr_a_reg <= '0;
            addr_b_reg <= top_a;
        end
        else if (ctl.rev_step)
        begin
            addr_a_reg <= addr_a_reg + AW'(1);
            addr_b_reg <= addr_b_reg - AW'(1);
        end
        else if (ctl.scan_step)
            addr_a_reg <= addr_a_reg - AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= '0;
            fill_reg <= '0;
            peak_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.load)
                kind_reg <= cmd.kind;
            if (ctl.fill_clr)
                fill_reg <= '0;
            else if (ctl.fill_inc)
                fill_reg <= fill_reg + FW'(1);
            else if (ctl.fill_dec)
                fill_reg <= fill_reg - FW'(1);
            if (ctl.wr_push && (fill_reg + FW'(1) > peak_reg))
                peak_reg <= fill_reg + FW'(1);
            if (ctl.out_load)
                rv_reg <= 1'b1;
            else if (res.ready)
                rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            r_status_reg <= ST_OK;
            r_val_reg    <= '0;
            r_tag_reg    <= 1'b0;
            r_found_reg  <= '1;
        end
        else
        begin
            if (ctl.set_status)
                r_status_reg <= ctl.status;
            if (ctl.set_read)
            begin
                r_val_reg <= data_a_reg[31:0];
                r_tag_reg <= data_a_reg[32];
            end
            if (ctl.set_found)
                r_found_reg <= COUNT_W'(addr_a_reg);
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.empty     = (fill_reg == '0);
    assign sts.full      = (fill_reg >= DEPTH_F);
    assign sts.few       = (fill_reg < FW'(2));
    assign sts.bad_rot   = (n_reg < FW'(2)) || (n_reg > fill_reg);
    assign sts.match     = (data_a_reg[32] == tag_reg) &&
                           words_equal(data_a_reg[31:0], val_reg, tag_reg);
    assign sts.scan_last = (addr_a_reg == '0);
    assign sts.ptr_meet  = (kind_reg == K_ROTATE) ? (addr_a_reg == addr_b_reg - AW'(1))
                                                  : (addr_a_reg >= addr_b_reg);
    assign sts.out_busy  = rv_reg && !res.ready;

    assign res.valid          = rv_reg;
    assign res.status         = r_status_reg;
    assign res.read_value     = r_val_reg;
    assign res.read_tag       = r_tag_reg;
    assign res.found_position = r_found_reg;
    assign res.depth_now      = COUNT_W'(fill_reg);
    assign res.high_water     = COUNT_W'(peak_reg);
endmodule
`default_nettype wire

>>> rtl/core/tse_control.sv
// ----------------------------------------------------------------------------
// tse_control
// Command sequencer for the tagged stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tagged_stack_engine_defines.svh"
module tse_control
    import tse_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   cmd_valid,
    output logic  cmd_ready,
    input  stat_t sts,
    output cmd_t  ctl
);
    state_t state_reg, state_next;
    logic   rot_first_reg, rot_first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_first_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_first_reg <= rot_first_next;
        end
    end

    // The result register is refilled only once the previous result has gone
    always_comb
    begin
        state_next     = state_reg;
        rot_first_next = rot_first_reg;
        case (state_reg)
            S_IDLE:
                if (cmd_valid && !sts.out_busy)
                    state_next = S_READ;
            S_READ:
            begin
                state_next = S_DONE;
                case (sts.kind)
                    K_POP, K_PEEK: if (!sts.empty) state_next = S_WAIT;
                    K_DUP:     if (!sts.empty && !sts.full) state_next = S_WAIT;
                    K_SWAP:    if (!sts.few) state_next = S_WAIT;
                    K_SEARCH:  if (!sts.empty) state_next = S_WAIT;
                    K_REVERSE: if (!sts.few) state_next = S_SWAP_A;
                    K_ROTATE:
                        if (!sts.bad_rot)
                        begin
                            state_next     = S_WAIT;
                            rot_first_next = 1'b1;
                        end
                    default: state_next = S_DONE;
                endcase
            end
            S_WAIT:
                case (sts.kind)
                    K_SWAP:   state_next = S_SWAP_B;
                    K_SEARCH: state_next = S_SCAN;
                    K_ROTATE:
                        // first pass latches the top word, then the shift loop starts
                        if (rot_first_reg)
                            rot_first_next = 1'b0;
                        else
                            state_next = S_ROT;
                    default:  state_next = S_DONE;
                endcase
            S_SCAN:
                if (sts.match || sts.scan_last)
                    state_next = S_DONE;
                else
                    state_next = S_WAIT;
            S_SWAP_A:
                if (sts.ptr_meet)
                    state_next = S_DONE;
                else
                    state_next = S_WAIT;
            S_SWAP_B: state_next = S_SWAP_W;
            S_SWAP_W:
                if (sts.kind == K_REVERSE)
                    state_next = S_SWAP_A;
                else
                    state_next = S_DONE;
            S_ROT:
                if (sts.ptr_meet)
                    state_next = S_DONE;
                else
                    state_next = S_WAIT;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // reverse routes its reads through WAIT -> SWAP_B
        if (state_reg == S_WAIT && sts.kind == K_REVERSE)
            state_next = S_SWAP_B;
    end

    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            S_IDLE:
                if (!sts.out_busy)
                begin
                    cmd_ready = 1'b1;
                    ctl.load  = cmd_valid;
                end
            S_READ:
                case (sts.kind)
                    K_PUSH:
                        if (sts.full)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status     = ST_FULL;
                        end
                        else
                        begin
                            ctl.wr_push  = 1'b1;
                            ctl.fill_inc = 1'b1;
                        end
                    K_POP, K_PEEK, K_SEARCH:
                        if (sts.empty)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status     = ST_FEW;
                        end
                        else
                            ctl.rd_a = 1'b1;
                    K_DUP:
                        if (sts.empty || sts.full)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status     = sts.empty ? ST_FEW : ST_FULL;
                        end
                        else
                            ctl.rd_a = 1'b1;
                    K_CLEAR: ctl.fill_clr = 1'b1;
                    K_SWAP, K_REVERSE:
                        if (sts.few)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status     = ST_FEW;
                        end
                        else
                        begin
                            ctl.rd_a     = (sts.kind == K_SWAP);
                            ctl.rev_init = (sts.kind == K_REVERSE);
                        end
                    K_ROTATE:
                        if (sts.bad_rot)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status     = ST_BADN;
                        end
                        else
                            ctl.rd_a = 1'b1;
                    default: ctl = '0;
                endcase
            S_WAIT:
                case (sts.kind)
                    K_POP:
                    begin
                        ctl.set_read = 1'b1;
                        ctl.fill_dec = 1'b1;
                    end
                    K_PEEK: ctl.set_read = 1'b1;
                    K_DUP:
                    begin
                        ctl.wr_dup   = 1'b1;
                        ctl.fill_inc = 1'b1;
                    end
                    K_SWAP, K_REVERSE: ctl.rd_b = 1'b1;
                    K_SEARCH: ctl.rd_a = 1'b1;
                    K_ROTATE:
                        if (rot_first_reg)
                            ctl.rot_init = 1'b1;
                        else
                            ctl.rd_a = 1'b1;
                    default: ctl = '0;
                endcase
            S_SCAN:
                if (sts.match)
                    ctl.set_found = 1'b1;
                else if (sts.scan_last)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_NOTFOUND;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    ctl.rd_a      = 1'b0;
                end
            S_SWAP_A:
                if (!sts.ptr_meet)
                    ctl.rd_a = 1'b1;
            S_SWAP_W:
            begin
                ctl.wr_b     = 1'b1;
                ctl.rev_step = (sts.kind == K_REVERSE);
            end
            S_SWAP_B:
                ctl.wr_a = 1'b1;
            S_ROT:
                ctl.rot_step = 1'b1;
            S_DONE:
                ctl.out_load = 1'b1;
            default: ctl = '0;
        endcase
    end

    `TSE_ASSERT_IMP(a_ready_idle, clk, rst_n, cmd_ready, state_reg == S_IDLE,
        "ready raised outside idle")
    `TSE_ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == S_DONE, state_reg == S_IDLE,
        "done not followed by idle")
    `TSE_ASSERT_IMP(a_one_write, clk, rst_n, ctl.wr_push, !ctl.wr_dup && !ctl.wr_a,
        "two store writes at once")
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tagged_stack_engine. A queue of commands feeds a
// clocked driver; an in-bench stack model predicts each result, and a clocked
// monitor compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import tse_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int CYC_LIMIT = 1000000;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] value;
        logic        tag;
        logic [10:0] count;
        bit          drain;    // hold back until every result is in
    } stack_cmd_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] rval;
        logic        rtag;
        logic [10:0] found;
        logic [10:0] depth;
        logic [10:0] peak;
    } stack_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tse_cmd_if cmd_ch ();
    tse_res_if res_ch ();

    logic        drv_valid = 1'b0;
    logic [3:0]  drv_kind  = '0;
    logic [31:0] drv_value = '0;
    logic        drv_tag   = 1'b0;
    logic [10:0] drv_count = '0;
    logic        mon_ready = 1'b0;

    assign cmd_ch.valid        = drv_valid;
    assign cmd_ch.kind         = drv_kind;
    assign cmd_ch.word_value   = drv_value;
    assign cmd_ch.word_tag     = drv_tag;
    assign cmd_ch.rotate_count = drv_count;
    assign res_ch.ready        = mon_ready;

    tagged_stack_engine #(.STACK_DEPTH(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    stack_cmd_t pending_cmds[$];
    stack_res_t expected_res[$];
    logic [32:0] shadow_stack[DEPTH];
    int unsigned shadow_fill = 0;
    int unsigned shadow_peak = 0;
    int unsigned error_count = 0;
    int unsigned cyc = 0;
    int unsigned hold_off = 0;
    bit          quiet;

    // no idling on either side for a stretch in the middle of the run
    assign quiet = (cyc >= 9000) && (cyc < 15000);

    function automatic bit float_same(logic [31:0] a, logic [31:0] b, logic tag);
        if (!tag)
            return a == b;
        if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
            return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic stack_res_t run_stack_cmd(logic [3:0] kind, logic [31:0] value,
                                                 logic tag, logic [10:0] count);
        stack_res_t r;
        logic [32:0] t;
        int unsigned lo;
        int unsigned hi;
        int unsigned base;
        r.status = ST_OK;
        r.rval   = '0;
        r.rtag   = 1'b0;
        r.found  = '1;
        case (kind)
            K_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_stack[shadow_fill] = {tag, value};
                    shadow_fill++;
                    if (shadow_fill > shadow_peak)
                        shadow_peak = shadow_fill;
                end
            end
            K_POP, K_PEEK:
            begin
                if (shadow_fill == 0)
                    r.status = ST_FEW;
                else
                begin
                    {r.rtag, r.rval} = shadow_stack[shadow_fill-1];
                    if (kind == K_POP)
                        shadow_fill--;
                end
            end
            K_CLEAR:
                shadow_fill = 0;
            K_DUP:
            begin
                if (shadow_fill == 0)
                    r.status = ST_FEW;
                else if (shadow_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_stack[shadow_fill] = shadow_stack[shadow_fill-1];
                    shadow_fill++;
                end
            end
            K_SWAP:
            begin
                if (shadow_fill < 2)
                    r.status = ST_FEW;
                else
                begin
                    t = shadow_stack[shadow_fill-1];
                    shadow_stack[shadow_fill-1] = shadow_stack[shadow_fill-2];
                    shadow_stack[shadow_fill-2] = t;
                end
            end
            K_ROTATE:
            begin
                if (count < 2 || count > shadow_fill)
                    r.status = ST_BADN;
                else
                begin
                    base = shadow_fill - count;
                    t = shadow_stack[shadow_fill-1];
                    for (int i = shadow_fill - 1; i > base; i--)
                        shadow_stack[i] = shadow_stack[i-1];
                    shadow_stack[base] = t;
                end
            end
            K_SEARCH:
            begin
                if (shadow_fill == 0)
                    r.status = ST_FEW;
                else
                begin
                    r.status = ST_NOTFOUND;
                    for (int i = shadow_fill - 1; i >= 0; i--)
                    begin
                        if (shadow_stack[i][32] == tag &&
                            float_same(shadow_stack[i][31:0], value, tag))
                        begin
                            r.status = ST_OK;
                            r.found  = i[10:0];
                            break;
                        end
                    end
                end
            end
            K_REVERSE:
            begin
                if (shadow_fill < 2)
                    r.status = ST_FEW;
                else
                begin
                    lo = 0;
                    hi = shadow_fill - 1;
                    while (lo < hi)
                    begin
                        t = shadow_stack[lo];
                        shadow_stack[lo] = shadow_stack[hi];
                        shadow_stack[hi] = t;
                        lo++;
                        hi--;
                    end
                end
            end
            default: ;
        endcase
        r.depth = shadow_fill[10:0];
        r.peak  = shadow_peak[10:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        stack_cmd_t c;
        if (!rst_n)
            drv_valid <= 1'b0;
        else
        begin
            if (drv_valid && cmd_ch.ready)
                expected_res.push_back(run_stack_cmd(drv_kind, drv_value, drv_tag, drv_count));
            if (!drv_valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() > 0 &&
                    !(pending_cmds[0].drain && (expected_res.size() > 0 || drv_valid)) &&
                    (quiet || $urandom_range(99) >= 36))
                begin
                    c = pending_cmds.pop_front();
                    drv_valid <= 1'b1;
                    drv_kind  <= c.kind;
                    drv_value <= c.value;
                    drv_tag   <= c.tag;
                    drv_count <= c.count;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, so the engine backs up and stalls its input
    always @(posedge clk)
    begin
        if (cyc == 6000)
            hold_off <= 400;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        stack_res_t e;
        bit bad;
        if (!rst_n)
            mon_ready <= 1'b0;
        else
        begin
            if (res_ch.valid && mon_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("tb: result transfer with nothing expected, status %0d",
                                 res_ch.status);
                end
                else
                begin
                    e = expected_res.pop_front();
                    bad = (res_ch.status !== e.status) || (res_ch.read_value !== e.rval) ||
                          (res_ch.read_tag !== e.rtag) || (res_ch.found_position !== e.found) ||
                          (res_ch.depth_now !== e.depth) || (res_ch.high_water !== e.peak);
                    if (bad)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"tb: mismatch exp st=%0d val=%h tag=%0d pos=%0d dep=%0d ",
                                      "hw=%0d got st=%0d val=%h tag=%0d pos=%0d dep=%0d hw=%0d"},
                                     e.status, e.rval, e.rtag, $signed(e.found), e.depth,
                                     e.peak, res_ch.status, res_ch.read_value, res_ch.read_tag,
                                     res_ch.found_position, res_ch.depth_now,
                                     res_ch.high_water);
                    end
                end
            end
            mon_ready <= (hold_off == 0) && (quiet || $urandom_range(99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYC_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic queue_cmd(logic [3:0] kind, logic [31:0] value = 0, logic tag = 0,
                             logic [10:0] count = 0, bit drain = 0);
        stack_cmd_t c;
        c.kind  = kind;
        c.value = value;
        c.tag   = tag;
        c.count = count;
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    // words from a small pool so searches hit, plus fully random ones
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FC0_0000;
            3: return 32'h7F80_0000;
            4: return 32'hFFFF_FFFF;
            5, 6: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned gd;
        int unsigned r;
        logic [3:0] k;
        logic [10:0] n;

        // directed: signed zeros, NaN, every command and its failure cases
        queue_cmd(K_POP);
        queue_cmd(K_PEEK);
        queue_cmd(K_DUP);
        queue_cmd(K_SWAP);
        queue_cmd(K_REVERSE);
        queue_cmd(K_SEARCH, 32'h0, 1'b0);
        queue_cmd(K_ROTATE, 0, 0, 11'd2);
        queue_cmd(K_PUSH, 32'h0000_0000, 1'b0, 11'h7FF);
        queue_cmd(K_PUSH, 32'h8000_0000, 1'b1);
        queue_cmd(K_PUSH, 32'h7FC0_0000, 1'b1);
        queue_cmd(K_SEARCH, 32'h0000_0000, 1'b1);
        queue_cmd(K_SEARCH, 32'h0000_0000, 1'b0);
        queue_cmd(K_SEARCH, 32'h7FC0_0000, 1'b1);
        queue_cmd(K_SEARCH, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(K_PEEK);
        queue_cmd(K_DUP);
        queue_cmd(K_SWAP);
        queue_cmd(K_ROTATE, 0, 0, 11'd3);
        queue_cmd(K_ROTATE, 0, 0, 11'd1);
        queue_cmd(K_ROTATE, 0, 0, 11'd5);
        queue_cmd(K_REVERSE);
        queue_cmd(4'd9);
        queue_cmd(4'd15, 32'hFFFF_FFFF, 1'b1, 11'h7FF);
        queue_cmd(K_POP);
        queue_cmd(K_CLEAR);

        // full stack: overflow, dup when full, whole-depth walks
        for (int i = 0; i < DEPTH; i++)
            queue_cmd(K_PUSH, $urandom, $urandom_range(1), 0, i == 0);
        queue_cmd(K_PUSH, 32'h1234_5678, 1'b0);
        queue_cmd(K_DUP);
        queue_cmd(K_ROTATE, 0, 0, 11'd1024);
        queue_cmd(K_ROTATE, 0, 0, 11'd1025);
        queue_cmd(K_ROTATE, 0, 0, 11'h7FF);
        queue_cmd(K_SEARCH, 32'h7FC0_0001, 1'b1);
        queue_cmd(K_REVERSE);
        queue_cmd(K_POP);
        queue_cmd(K_CLEAR);
        queue_cmd(K_PEEK);

        gd = 0;
        for (int i = 0; i < 870; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)      k = (gd > 40) ? K_POP : K_PUSH;
            else if (r < 48) k = K_POP;
            else if (r < 54) k = K_PEEK;
            else if (r < 57) k = K_CLEAR;
            else if (r < 64) k = K_DUP;
            else if (r < 71) k = K_SWAP;
            else if (r < 80) k = K_ROTATE;
            else if (r < 92) k = K_SEARCH;
            else if (r < 97) k = K_REVERSE;
            else             k = 4'($urandom_range(15, 9));
            if (k == K_ROTATE && gd >= 2 && $urandom_range(9) < 8)
                n = 11'($urandom_range(gd, 2));
            else
                n = 11'($urandom_range(2047));
            queue_cmd(k, pick_word(), $urandom_range(1), n, i == 450);
            case (k)
                K_PUSH: gd = gd + 1;
                K_POP:  if (gd > 0) gd = gd - 1;
                K_CLEAR: gd = 0;
                K_DUP:  if (gd > 0) gd = gd + 1;
                default: ;
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() > 0 || drv_valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        if (error_count == 0 && expected_res.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tse_pkg.sv
rtl/core/tse_if.sv
rtl/core/tse_datapath.sv
rtl/core/tse_control.sv
rtl/core/tagged_stack_engine.sv
verif/tb.sv
